@@ sv/critically_damped_smoother_macros.svh @@
// ----------------------------------------------------------------------------
// critically_damped_smoother assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CRITICALLY_DAMPED_SMOOTHER_MACROS_SVH
`define CRITICALLY_DAMPED_SMOOTHER_MACROS_SVH

// same-cycle implication
`define CDS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("critically_damped_smoother: same-cycle check failed");

// next-cycle implication
`define CDS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("critically_damped_smoother: next-cycle check failed");

`endif

@@ sv/cds_pkg.sv @@
// ----------------------------------------------------------------------------
// cds_pkg
// Constants, saturating helpers and unit request types for the smoother.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package cds_pkg;

	localparam int FRAC_BITS = 16;

	// smooth time floor: round(0.0001 * 2^F), at least one lsb
	localparam int ST_MIN_RAW = ((1 << FRAC_BITS) + 5000) / 10000;
	localparam logic [31:0] ST_MIN = (ST_MIN_RAW == 0) ? 32'd1 : 32'(ST_MIN_RAW);

	localparam logic [62:0] BIG = 63'h4000_0000_0000_0000;
	localparam logic signed [63:0] BIG_S = 64'sh4000_0000_0000_0000;
	localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
	localparam logic [63:0] OMEGA_NUM = 64'd1 << (2 * FRAC_BITS + 1);
	localparam logic [63:0] DECAY_NUM = 64'd1 << (2 * FRAC_BITS);
	localparam logic signed [63:0] C48_Q32 = 64'sd2061584256;
	localparam logic signed [63:0] C235_Q32 = 64'sd1009317312;
	localparam logic [30:0] SPEED_UNLIMITED = 31'h7FFF_FFFF;
	localparam logic signed [63:0] FULL_TURN = 64'sd360 <<< FRAC_BITS;
	localparam logic signed [63:0] HALF_TURN = 64'sd180 <<< FRAC_BITS;

	localparam logic [6:0] MUL_STEPS = 7'd63;
	localparam logic [6:0] DIV_STEPS = 7'd64;

	typedef enum logic [1:0] {
		REG_SMOOTH_TIME = 2'd0,
		REG_MAX_SPEED   = 2'd1,
		REG_ANGLE_MODE  = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} unit_op_t;

	// request to the serial unit: mul uses x*y magnitudes, div uses x/y
	typedef struct packed {
		logic        start;
		unit_op_t    op;
		logic [63:0] x;
		logic [63:0] y;
	} unit_req_t;

	typedef struct packed {
		logic         done;
		logic [125:0] prod;
		logic [63:0]  quo;
		logic [63:0]  rem;
	} unit_rsp_t;

	function automatic logic signed [63:0] sclamp(input logic signed [63:0] v);
		if (v > BIG_S)
			return BIG_S;
		if (v < -BIG_S)
			return -BIG_S;
		return v;
	endfunction

	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
			input logic signed [63:0] b);
		return sclamp(sclamp(a) + sclamp(b));
	endfunction

	// magnitude of a clamped value, at most 2^62
	function automatic logic [62:0] mag63(input logic signed [63:0] v);
		logic signed [63:0] c;
		c = sclamp(v);
		return (c < 0) ? 63'(-c) : 63'(c);
	endfunction

	// shift a full product right by F or 32, saturate at 2^62
	function automatic logic [62:0] umul_fin(input logic [125:0] p, input logic hi);
		logic [63:0] s;
		if (|p[125:64])
			return BIG;
		s = hi ? (p[63:0] >> 32) : (p[63:0] >> FRAC_BITS);
		return (s > {1'b0, BIG}) ? BIG : s[62:0];
	endfunction

	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

endpackage
`default_nettype wire

@@ sv/cds_serial_unit.sv @@
// ----------------------------------------------------------------------------
// cds_serial_unit
// Bit-serial shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cds_serial_unit import cds_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire unit_req_t req,
	output unit_rsp_t      rsp
);

	logic         busy_q;
	logic         done_q;
	unit_op_t     op_q;
	logic [6:0]   cnt_q;
	logic [125:0] prod_q;
	logic [62:0]  mcand_q;
	logic [63:0]  rem_q;
	logic [63:0]  quo_q;
	logic [63:0]  den_q;

	// one multiplier bit: add multiplicand into upper half, shift right
	logic [63:0] mul_sum;
	logic [63:0] mul_hi;
	assign mul_sum = {1'b0, prod_q[125:63]} + {1'b0, mcand_q};
	assign mul_hi = prod_q[0] ? mul_sum : {1'b0, prod_q[125:63]};

	// one quotient bit: trial subtract
	logic [64:0] div_r;
	logic        div_ge;
	logic [64:0] div_d;
	assign div_r = {rem_q, quo_q[63]};
	assign div_ge = div_r >= {1'b0, den_q};
	assign div_d = div_r - {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			op_q <= OP_MUL;
		end else begin
			done_q <= busy_q && (cnt_q == 7'd0);
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				op_q <= req.op;
				cnt_q <= (req.op == OP_DIV) ? DIV_STEPS - 7'd1 : MUL_STEPS - 7'd1;
			end else if (busy_q) begin
				if (cnt_q == 7'd0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 7'd1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			prod_q <= {63'd0, req.y[62:0]};
			mcand_q <= req.x[62:0];
			rem_q <= '0;
			quo_q <= req.x;
			den_q <= req.y;
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				prod_q <= {mul_hi, prod_q[62:1]};
			end else if (div_ge) begin
				rem_q <= div_d[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= div_r[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = prod_q;
	assign rsp.quo = quo_q;
	assign rsp.rem = rem_q;

endmodule
`default_nettype wire

@@ sv/critically_damped_smoother.sv @@
// ----------------------------------------------------------------------------
// critically_damped_smoother
// Critically damped follower: one value/velocity step per input item.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                   handshake
//  s_*       in   current_value, target_value, time_step    tvalid/tready
//  m_*       out  next_value, next_velocity                 tvalid/tready
//  wr_*      in   smooth_time, max_speed, angle_mode        wr_en
//
//  Each item runs through one shared bit-serial mul/div unit: ten multiplies
//  and two divides, plus the accept, error and final states. A speed limit
//  adds one multiply and angle mode one divide. One item at a time; the next
//  may be accepted while a result waits. A stalled output holds the sequencer
//  in its final state.
//  Reset clears control and velocity, sets configuration defaults; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "critically_damped_smoother_macros.svh"
module critically_damped_smoother import cds_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [95:0] s_tdata,   // current_value, target_value, time_step
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // next_value, next_velocity
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [31:0] wr_data
);

	typedef enum logic [16:0] {
		ST_IDLE  = 17'h00001,
		ST_OMEGA = 17'h00002,
		ST_X     = 17'h00004,
		ST_X2    = 17'h00008,
		ST_X3    = 17'h00010,
		ST_T1    = 17'h00020,
		ST_T2    = 17'h00040,
		ST_DECAY = 17'h00080,
		ST_WRAP  = 17'h00100,
		ST_ERR   = 17'h00200,
		ST_LIM   = 17'h00400,
		ST_A     = 17'h00800,
		ST_N7    = 17'h01000,
		ST_B     = 17'h02000,
		ST_NV    = 17'h04000,
		ST_C     = 17'h08000,
		ST_FIN   = 17'h10000
	} state_t;

	state_t state_q;
	logic   launched_q;
	logic   neg_q;

	logic [31:0] smooth_time_q;
	logic [30:0] max_speed_q;
	logic        angle_mode_q;
	logic signed [31:0] vel_q;

	logic signed [31:0] cur_q;
	logic signed [63:0] tgt_q;
	logic [31:0] dt_q;
	logic [31:0] st_q;
	logic [31:0] omega_q;
	logic [62:0] x_q;
	logic [62:0] x2_q;
	logic [62:0] x3_q;
	logic [62:0] t1_q;
	logic [62:0] den_q;
	logic [63:0] decay_q;
	logic signed [63:0] err_q;
	logic signed [63:0] s_q;
	logic signed [63:0] n7_q;
	logic signed [63:0] nv_q;
	logic signed [63:0] nx_q;
	logic out_valid_q;
	logic [63:0] out_data_q;

	unit_req_t req;
	unit_rsp_t rsp;

	cds_serial_unit u_unit (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	// operand select per step
	logic signed [63:0] mx;
	logic signed [63:0] my;
	logic               hi_sh;
	logic               is_op;
	unit_op_t           op_sel;
	logic signed [63:0] diff;

	assign diff = tgt_q - 64'(cur_q);

	always_comb begin
		mx = '0;
		my = '0;
		hi_sh = 1'b0;
		is_op = 1'b1;
		op_sel = OP_MUL;
		case (state_q)
			ST_OMEGA: begin
				op_sel = OP_DIV;
				mx = OMEGA_NUM;
				my = 64'(st_q);
			end
			ST_X: begin
				mx = 64'(omega_q);
				my = 64'(dt_q);
			end
			ST_X2: begin
				mx = 64'(x_q);
				my = 64'(x_q);
			end
			ST_X3: begin
				mx = 64'(x2_q);
				my = 64'(x_q);
			end
			ST_T1: begin
				mx = 64'(x2_q);
				my = C48_Q32;
				hi_sh = 1'b1;
			end
			ST_T2: begin
				mx = 64'(x3_q);
				my = C235_Q32;
				hi_sh = 1'b1;
			end
			ST_DECAY: begin
				op_sel = OP_DIV;
				mx = DECAY_NUM + {2'b0, den_q[62:1]};
				my = 64'(den_q);
			end
			ST_WRAP: begin
				op_sel = OP_DIV;
				mx = (diff < 0) ? -diff : diff;
				my = FULL_TURN;
			end
			ST_LIM: begin
				mx = 64'(max_speed_q);
				my = 64'(st_q);
			end
			ST_A: begin
				mx = 64'(omega_q);
				my = err_q;
			end
			ST_N7: begin
				mx = s_q;
				my = 64'(dt_q);
			end
			ST_B: begin
				mx = 64'(omega_q);
				my = n7_q;
			end
			ST_NV: begin
				mx = s_q;
				my = decay_q;
			end
			ST_C: begin
				mx = sadd(err_q, n7_q);
				my = decay_q;
			end
			default: is_op = 1'b0;
		endcase
	end

	// unit request: divides pass raw operands, multiplies pass magnitudes
	assign req.start = is_op && !launched_q;
	assign req.op = op_sel;
	assign req.x = (op_sel == OP_DIV) ? mx : {1'b0, mag63(mx)};
	assign req.y = (op_sel == OP_DIV) ? my : {1'b0, mag63(my)};

	// finished product, unsigned and signed
	logic [62:0] res_m;
	logic signed [63:0] res_s;
	logic        adv;
	assign res_m = umul_fin(rsp.prod, hi_sh);
	assign res_s = neg_q ? -$signed({1'b0, res_m}) : $signed({1'b0, res_m});
	assign adv = launched_q && rsp.done;

	// angle wrap from the remainder
	logic signed [63:0] wrap_d;
	logic signed [63:0] wrap_m;
	always_comb begin
		wrap_m = $signed(rsp.rem);
		if (diff < 0 && rsp.rem != 64'd0)
			wrap_m = FULL_TURN - $signed(rsp.rem);
		wrap_d = (wrap_m > HALF_TURN) ? wrap_m - FULL_TURN : wrap_m;
	end

	// denominator from the polynomial terms
	logic [62:0] den_sum;
	assign den_sum = 63'(sadd(sadd($signed(ONE), 64'(x_q)), sadd(64'(t1_q), 64'(res_m))));

	// overshoot test and final values
	logic        over;
	logic signed [63:0] fin_x;
	logic signed [63:0] fin_v;
	assign over = (diff > 0) == (nx_q > tgt_q);
	assign fin_x = over ? tgt_q : nx_q;
	assign fin_v = over ? 64'sd0 : nv_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_time_q <= 32'd1 << FRAC_BITS;
			max_speed_q <= SPEED_UNLIMITED;
			angle_mode_q <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_SMOOTH_TIME: smooth_time_q <= wr_data;
				REG_MAX_SPEED:   max_speed_q <= wr_data[30:0];
				REG_ANGLE_MODE:  angle_mode_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			launched_q <= 1'b0;
			out_valid_q <= 1'b0;
			vel_q <= '0;
		end else begin
			// output register: load from the final state, clear on accept
			if (state_q == ST_FIN && (!out_valid_q || m_tready))
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			if (req.start)
				launched_q <= 1'b1;
			else if (adv)
				launched_q <= 1'b0;
			case (state_q)
				ST_IDLE:  if (s_tvalid) state_q <= ST_OMEGA;
				ST_OMEGA: if (adv) state_q <= ST_X;
				ST_X:     if (adv) state_q <= ST_X2;
				ST_X2:    if (adv) state_q <= ST_X3;
				ST_X3:    if (adv) state_q <= ST_T1;
				ST_T1:    if (adv) state_q <= ST_T2;
				ST_T2:    if (adv) state_q <= ST_DECAY;
				ST_DECAY: if (adv) state_q <= angle_mode_q ? ST_WRAP : ST_ERR;
				ST_WRAP:  if (adv) state_q <= ST_ERR;
				ST_ERR:   state_q <= (max_speed_q != SPEED_UNLIMITED) ? ST_LIM : ST_A;
				ST_LIM:   if (adv) state_q <= ST_A;
				ST_A:     if (adv) state_q <= ST_N7;
				ST_N7:    if (adv) state_q <= ST_B;
				ST_B:     if (adv) state_q <= ST_NV;
				ST_NV:    if (adv) state_q <= ST_C;
				ST_C:     if (adv) state_q <= ST_FIN;
				ST_FIN: begin
					if (!out_valid_q || m_tready) begin
						vel_q <= $signed(sat32(fin_v));
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req.start)
			neg_q <= (sclamp(mx) < 0) != (sclamp(my) < 0);
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cur_q <= $signed(s_tdata[31:0]);
					tgt_q <= 64'($signed(s_tdata[63:32]));
					dt_q <= s_tdata[95:64];
					st_q <= (smooth_time_q < ST_MIN) ? ST_MIN : smooth_time_q;
				end
			end
			ST_OMEGA: if (adv) omega_q <= (|rsp.quo[63:32]) ? 32'hFFFF_FFFF : rsp.quo[31:0];
			ST_X:     if (adv) x_q <= res_m;
			ST_X2:    if (adv) x2_q <= res_m;
			ST_X3:    if (adv) x3_q <= res_m;
			ST_T1:    if (adv) t1_q <= res_m;
			ST_T2:    if (adv) den_q <= den_sum;
			ST_DECAY: if (adv) decay_q <= rsp.quo;
			ST_WRAP:  if (adv) tgt_q <= 64'(cur_q) + wrap_d;
			ST_ERR:   err_q <= 64'(cur_q) - tgt_q;
			ST_LIM: begin
				if (adv) begin
					if (err_q > $signed({1'b0, res_m}))
						err_q <= $signed({1'b0, res_m});
					else if (err_q < -$signed({1'b0, res_m}))
						err_q <= -$signed({1'b0, res_m});
				end
			end
			ST_A:  if (adv) s_q <= sadd(64'(vel_q), res_s);
			ST_N7: if (adv) n7_q <= res_s;
			ST_B:  if (adv) s_q <= sadd(64'(vel_q), -res_s);
			ST_NV: if (adv) nv_q <= res_s;
			ST_C:  if (adv) nx_q <= sadd(64'(cur_q) - err_q, res_s);
			ST_FIN: begin
				if (!out_valid_q || m_tready)
					out_data_q <= {sat32(fin_v), sat32(fin_x)};
			end
			default: ;
		endcase
	end

	`CDS_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	`CDS_ASSERT_IMP(a_done_when_launched, rsp.done, launched_q)
	`CDS_ASSERT_IMP(a_result_from_fin, $rose(m_tvalid), $past(state_q == ST_FIN))
	`CDS_ASSERT_IMP(a_no_start_idle, req.start, state_q != ST_IDLE && state_q != ST_FIN)

endmodule
`default_nettype wire
